[src/signed_vertex_angle_on_sphere_assert.svh]
// Assertion macros shared by the signed vertex angle design.
`ifndef SIGNED_VERTEX_ANGLE_ON_SPHERE_ASSERT_SVH
`define SIGNED_VERTEX_ANGLE_ON_SPHERE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/sva_pkg.sv]
// Package with constants, types and the arctangent table.
`default_nettype none
package sva_pkg;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 32;
  localparam int unsigned VecW = 16;
  localparam int unsigned DotW = 34;
  localparam int unsigned SqW = 62;
  localparam int unsigned RootW = 31;
  localparam int unsigned CxW = 34;
  localparam int unsigned ZW = 34;
  localparam int unsigned TripW = 50;
  localparam int unsigned AngW = 16;

  typedef struct packed {
    logic signed [VecW-1:0] a_x;
    logic signed [VecW-1:0] a_y;
    logic signed [VecW-1:0] a_z;
    logic signed [VecW-1:0] b_x;
    logic signed [VecW-1:0] b_y;
    logic signed [VecW-1:0] b_z;
    logic signed [VecW-1:0] p_x;
    logic signed [VecW-1:0] p_y;
    logic signed [VecW-1:0] p_z;
  } in_t;

  typedef struct packed {
    logic [AngW-1:0] angle_turns;
    logic            reflex;
  } out_t;

  function automatic logic [31:0] atan_f(input int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
      3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
      9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
      15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
      21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
      24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
      27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
      30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[src/sva_if.sv]
// Valid/ready channel interface with a generic payload.
`default_nettype none
interface sva_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/sva_front.sv]
// Front stages: products, dot product clamp, cross and triple products, radicand and sign.
`default_nettype none
module sva_front (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire sva_pkg::in_t                      in_i,
  output logic signed [sva_pkg::CxW-1:0]         c_o,
  output logic        [sva_pkg::SqW-1:0]         rad_o,
  output logic                                   neg_o
);
  logic signed [31:0] pab_q [3];
  logic signed [31:0] pcr_q [6];
  logic signed [15:0] p_q [3];
  logic signed [33:0] dot_d;
  logic signed [33:0] dcl_d;
  logic signed [33:0] c_q;
  logic signed [32:0] cr_d [3];
  logic signed [32:0] cr_q [3];
  logic signed [15:0] p2_q [3];
  logic signed [49:0] tp_q [3];
  logic signed [31:0] cn_d;
  logic signed [63:0] csq_d;
  logic signed [33:0] c2_q;
  logic signed [33:0] c3_q;
  logic [61:0] rad_q;
  logic neg_q;

  assign dot_d = 34'(pab_q[0]) + 34'(pab_q[1]) + 34'(pab_q[2]);
  always_comb begin
    if (dot_d > 34'sd1073741824) begin
      dcl_d = 34'sd1073741824;
    end else if (dot_d < -34'sd1073741824) begin
      dcl_d = -34'sd1073741824;
    end else begin
      dcl_d = dot_d;
    end
    cr_d[0] = 33'(pcr_q[0]) - 33'(pcr_q[1]);
    cr_d[1] = 33'(pcr_q[2]) - 33'(pcr_q[3]);
    cr_d[2] = 33'(pcr_q[4]) - 33'(pcr_q[5]);
  end
  assign cn_d = 32'(c2_q);
  assign csq_d = cn_d * cn_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pab_q[0] <= in_i.a_x * in_i.b_x;
      pab_q[1] <= in_i.a_y * in_i.b_y;
      pab_q[2] <= in_i.a_z * in_i.b_z;
      pcr_q[0] <= in_i.a_y * in_i.b_z;
      pcr_q[1] <= in_i.a_z * in_i.b_y;
      pcr_q[2] <= in_i.a_z * in_i.b_x;
      pcr_q[3] <= in_i.a_x * in_i.b_z;
      pcr_q[4] <= in_i.a_x * in_i.b_y;
      pcr_q[5] <= in_i.a_y * in_i.b_x;
      p_q[0] <= in_i.p_x;
      p_q[1] <= in_i.p_y;
      p_q[2] <= in_i.p_z;
      c_q <= -dcl_d;
      cr_q <= cr_d;
      p2_q <= p_q;
      c2_q <= c_q;
      for (int k = 0; k < 3; k++) begin
        tp_q[k] <= 50'(p2_q[k]) * 50'(cr_q[k]);
      end
      c3_q <= c2_q;
      rad_q <= 62'(64'd1 << 60) - 62'(csq_d);
      neg_q <= (tp_q[0] + tp_q[1] + tp_q[2]) < 50'sd0;
    end
  end
  // c, rad and the sign all leave after the fourth stage.
  assign c_o = c3_q;
  assign rad_o = rad_q;
  assign neg_o = neg_q;
endmodule
`default_nettype wire

[src/sva_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module sva_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic        [sva_pkg::SqW-1:0]    rad_i,
  input  wire logic signed [sva_pkg::CxW-1:0]    c_i,
  input  wire logic                              neg_i,
  output logic        [sva_pkg::RootW-1:0]       root_o,
  output logic signed [sva_pkg::CxW-1:0]         c_o,
  output logic                                   neg_o
);
  localparam int unsigned N = sva_pkg::RootW;
  logic [63:0] rem_q [N+1];
  logic [N-1:0] res_q [N+1];
  logic signed [sva_pkg::CxW-1:0] c_q [N+1];
  logic neg_q [N+1];

  always_comb begin
    rem_q[0] = 64'(rad_i);
    res_q[0] = '0;
    c_q[0] = c_i;
    neg_q[0] = neg_i;
  end

  for (genvar g = 0; g < N; g++) begin : g_bit
    logic [63:0] trial;
    assign trial = {res_q[g], 2'b01} << (2 * (N - 1 - g));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[g] >= trial) begin
          rem_q[g+1] <= rem_q[g] - trial;
          res_q[g+1] <= {res_q[g][N-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= rem_q[g];
          res_q[g+1] <= {res_q[g][N-2:0], 1'b0};
        end
        c_q[g+1] <= c_q[g];
        neg_q[g+1] <= neg_q[g];
      end
    end
  end
  assign root_o = res_q[N];
  assign c_o = c_q[N];
  assign neg_o = neg_q[N];
endmodule
`default_nettype wire

[src/sva_cordic.sv]
// Vectoring rotator stages, clamp, mirror and output rounding.
`default_nettype none
module sva_cordic #(
  parameter int unsigned CORDIC_STEPS = sva_pkg::CordicStepsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic        [sva_pkg::RootW-1:0]  root_i,
  input  wire logic signed [sva_pkg::CxW-1:0]    c_i,
  input  wire logic                              neg_i,
  output sva_pkg::out_t                          res_o
);
  localparam int unsigned S =
    (CORDIC_STEPS > sva_pkg::CordicStepsMax) ? sva_pkg::CordicStepsMax : CORDIC_STEPS;
  localparam int unsigned W = sva_pkg::CxW + 1;
  logic signed [W-1:0] x_q [S+1];
  logic signed [W-1:0] y_q [S+1];
  logic signed [sva_pkg::ZW-1:0] z_q [S+1];
  logic neg_q [S+1];
  logic signed [sva_pkg::ZW-1:0] zc_d;
  logic [32:0] a_d;
  sva_pkg::out_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (c_i < 0) begin
        x_q[0] <= W'($signed({1'b0, root_i}));
        y_q[0] <= -W'(c_i);
        z_q[0] <= sva_pkg::ZW'(64'd1 << 30);
      end else begin
        x_q[0] <= W'(c_i);
        y_q[0] <= W'($signed({1'b0, root_i}));
        z_q[0] <= '0;
      end
      neg_q[0] <= neg_i;
    end
  end

  for (genvar g = 0; g < S; g++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] + sva_pkg::ZW'(sva_pkg::atan_f(g));
        end else begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] - sva_pkg::ZW'(sva_pkg::atan_f(g));
        end
        neg_q[g+1] <= neg_q[g];
      end
    end
  end

  always_comb begin
    if (z_q[S] < 0) begin
      zc_d = '0;
    end else if (z_q[S] > sva_pkg::ZW'(64'd1 << 31)) begin
      zc_d = sva_pkg::ZW'(64'd1 << 31);
    end else begin
      zc_d = z_q[S];
    end
    if (neg_q[S]) begin
      a_d = 33'(64'd1 << 32) - 33'(zc_d);
    end else begin
      a_d = 33'(zc_d);
    end
  end
  wire logic [33:0] rnd_d = 34'(a_d) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.angle_turns <= rnd_d[31:16];
      res_q.reflex <= neg_q[S];
    end
  end
  assign res_o = res_q;
endmodule
`default_nettype wire

[src/signed_vertex_angle_on_sphere.sv]
// Top level of the signed vertex angle pipeline.
//  channel | dir | payload
//  in_ch   | in  | a_x..p_z, nine signed 16-bit components
//  out_ch  | out | angle_turns (16 bits), reflex (1 bit)
// One transfer enters per cycle while the output is not stalled; data passes the
// square root stages (one result bit each) and the rotator stages (one step each).
// Reset clears only the valid bits; data registers are not reset.
// The whole pipeline advances together; a stall at the output holds every stage,
// and the input is accepted whenever the output is empty or being taken.
`default_nettype none
`include "signed_vertex_angle_on_sphere_assert.svh"
module signed_vertex_angle_on_sphere #(
  parameter int unsigned CORDIC_STEPS = sva_pkg::CordicStepsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sva_if.sink       in_ch,
  sva_if.source     out_ch
);
  localparam int unsigned S =
    (CORDIC_STEPS > sva_pkg::CordicStepsMax) ? sva_pkg::CordicStepsMax : CORDIC_STEPS;
  localparam int unsigned Lat = 4 + sva_pkg::RootW + 1 + S + 1;

  logic [Lat-1:0] vld_q;
  logic en;
  logic signed [sva_pkg::CxW-1:0] c_a, c_b;
  logic [sva_pkg::SqW-1:0] rad;
  logic [sva_pkg::RootW-1:0] root;
  logic neg_a, neg_b;

  assign en = !vld_q[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_ch.valid};
    end
  end

  sva_front u_front (
    .clk_i(clk_i), .en_i(en), .in_i(in_ch.data), .c_o(c_a), .rad_o(rad), .neg_o(neg_a)
  );
  sva_sqrt u_sqrt (
    .clk_i(clk_i), .en_i(en), .rad_i(rad), .c_i(c_a), .neg_i(neg_a),
    .root_o(root), .c_o(c_b), .neg_o(neg_b)
  );
  sva_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .en_i(en), .root_i(root), .c_i(c_b), .neg_i(neg_b), .res_o(out_ch.data)
  );

  assign out_ch.valid = vld_q[Lat-1];

  `SVA_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_ch.valid, in_ch.ready)
  `SVA_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.data))
  `SVA_ASSERT_NEXT(a_valid_frozen, clk_i, rst_ni, !en, $stable(vld_q))
endmodule
`default_nettype wire
